// File: src/lru_pkg.sv
// Shared constants and types for the LRU replacement list.
`default_nettype none

package lru_pkg;

    // Default number of buffer frames the list can track.
    localparam int FRAMES_DEF = 64;

    // Width of a frame number on the stream ports.
    localparam int FRAME_W = 6;

    // Stream data width: frame number padded to whole bytes.
    localparam int TDATA_W = ((FRAME_W + 7) / 8) * 8;

    // Operation codes carried in the input tuser.
    typedef enum logic [0:0] {
        FUNC_ACCESS = 1'b0,
        FUNC_EVICT  = 1'b1
    } func_t;

endpackage

`default_nettype wire

// File: src/lru_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module lru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // Read data holds its value while no read is issued.
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/lru_replacement_list.sv
// LRU replacement list: recency-ordered frame list kept in a RAM and walked per access.
//
// The block keeps buffer frame numbers in a RAM ordered from most to least recently
// used. An access word (tuser = 0) moves the named frame to the front: the list is
// walked from the front one entry per clock, each entry shifted back by one place,
// until the frame or the end of the list is reached; the block takes no new word until
// the walk is done. Accesses to frame numbers at or above FRAMES are dropped. An evict
// word (tuser = 1) returns the tail of the list through the ST_EVICT state, which waits
// while the output is stalled; on an empty list it returns found = 0 with victim 0.
// The cost of an access is set by the single RAM read port, which sees one entry per
// cycle. The list RAM needs no clearing after reset; only the entry count, the state
// and the output valid are reset.
`default_nettype none

module lru_replacement_list #(
    parameter int FRAMES = lru_pkg::FRAMES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [lru_pkg::TDATA_W-1:0] s_tdata,   // [5:0] frame, rest zero
    input  wire logic                        s_tuser,   // [0] func
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [lru_pkg::TDATA_W-1:0] m_tdata,   // [5:0] victim, rest zero
    output logic                             m_tuser    // [0] found
);

    import lru_pkg::*;

    localparam int AW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EVICT
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [FRAME_W-1:0] target_reg, target_next;
    logic [FRAME_W-1:0] carry_reg, carry_next;
    logic               empty_reg, empty_next;
    logic               out_valid_reg, out_valid_next;
    logic [FRAME_W-1:0] victim_reg, victim_next;
    logic               found_reg, found_next;

    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [FRAME_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [FRAME_W-1:0] ram_rd_data;

    logic               in_fire;
    logic [FRAME_W-1:0] in_frame;
    func_t              in_func;
    logic               frame_ok;
    logic [CW-1:0]      count_dec;
    logic [CW-1:0]      idx_inc;
    logic               at_end;
    logic               hit;
    logic               out_free;

    lru_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (FRAMES)
    ) u_list_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign in_frame  = s_tdata[FRAME_W-1:0];
    assign in_func   = func_t'(s_tuser);
    assign frame_ok  = (32'(in_frame) < FRAMES);
    assign count_dec = count_reg - CW'(1);
    assign idx_inc   = idx_reg + CW'(1);
    assign at_end    = (idx_reg == count_reg);
    assign hit       = (ram_rd_data == target_reg);
    assign out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(victim_reg);
    assign m_tuser  = found_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        target_next    = target_reg;
        carry_next     = carry_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg && !m_tready;
        victim_next    = victim_reg;
        found_next     = found_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = idx_reg[AW-1:0];
        ram_wr_data    = carry_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = idx_inc[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_func)
                        FUNC_ACCESS:
                        begin
                            if (frame_ok)
                            begin
                                target_next = in_frame;
                                carry_next  = in_frame;
                                idx_next    = '0;
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = '0;
                                state_next  = ST_WALK;
                            end
                        end
                        FUNC_EVICT:
                        begin
                            empty_next  = (count_reg == '0);
                            ram_rd_addr = count_dec[AW-1:0];
                            if (count_reg != '0)
                            begin
                                count_next = count_dec;
                                ram_rd_en  = 1'b1;
                            end
                            state_next = ST_EVICT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // Each step writes the carried frame into the current slot (not past the end of a full
                // list) and, unless the walk ends there, picks up the old entry, which moves back by one place.
                if (at_end)
                begin
                    if (count_reg < CW'(FRAMES))
                    begin
                        ram_wr_en  = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    state_next = ST_IDLE;
                end
                else if (hit)
                begin
                    ram_wr_en  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_wr_en  = 1'b1;
                    carry_next = ram_rd_data;
                    idx_next   = idx_inc;
                    ram_rd_en  = 1'b1;
                end
            end
            ST_EVICT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    victim_next    = empty_reg ? '0 : ram_rd_data;
                    found_next     = !empty_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        target_reg <= target_next;
        carry_reg  <= carry_next;
        empty_reg  <= empty_next;
        victim_reg <= victim_next;
        found_reg  <= found_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(FRAMES))
        else $error("entry count exceeds the number of frames");

    a_walk_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (idx_reg <= count_reg))
        else $error("list walk ran past the end of the list");

    a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == ST_WALK))
        else $error("list RAM written outside a walk");

    a_evict_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_func == FUNC_EVICT) && (count_reg != '0))
        |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("evict did not shorten the list by one");

    a_empty_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("empty evict returned a nonzero victim");

endmodule

`default_nettype wire

// File: test/tb_lru_replacement_list.sv
// Testbench for the LRU replacement list: queued stimulus, clocked driver and monitor.
`default_nettype none

module tb_lru_replacement_list;

    timeunit 1ns;
    timeprecision 1ps;

    import lru_pkg::*;

    localparam int FRAMES = FRAMES_DEF;

    typedef struct {
        func_t              func;
        logic [FRAME_W-1:0] frame;
        bit                 drain_first;
    } stim_word_t;

    typedef struct {
        logic [FRAME_W-1:0] victim;
        logic               found;
    } victim_word_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;   // [5:0] frame, rest zero
    logic               s_tuser;   // [0] func
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;   // [5:0] victim, rest zero
    logic               m_tuser;   // [0] found

    stim_word_t         stim_q[$];
    stim_word_t         next_word;
    victim_word_t       victim_exp_q[$];
    victim_word_t       got_word;
    logic [FRAME_W-1:0] recency_model[$];

    bit word_taken;
    int total_words;
    int words_taken;
    int err_count;
    int access_count;
    int evict_count;
    int empty_evict_count;
    int max_depth;
    int drain_pauses;

    lru_replacement_list #(.FRAMES(FRAMES)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    // Predicts the effect of one accepted word on the recency list.
    task automatic apply_word(input func_t func, input logic [FRAME_W-1:0] frame);
        victim_word_t v;
        int           hit_pos;
        hit_pos = -1;
        if (func == FUNC_ACCESS)
        begin
            access_count++;
            if (int'(frame) < FRAMES)
            begin
                foreach (recency_model[i])
                begin
                    if (hit_pos < 0 && recency_model[i] == frame)
                        hit_pos = i;
                end
                if (hit_pos >= 0)
                    recency_model.delete(hit_pos);
                if (hit_pos >= 0 || recency_model.size() < FRAMES)
                    recency_model.push_front(frame);
                if (recency_model.size() > max_depth)
                    max_depth = recency_model.size();
            end
        end
        else
        begin
            evict_count++;
            if (recency_model.size() == 0)
            begin
                empty_evict_count++;
                v.victim = '0;
                v.found  = 1'b0;
            end
            else
            begin
                v.victim = recency_model.pop_back();
                v.found  = 1'b1;
            end
            victim_exp_q.push_back(v);
        end
    endtask

    task automatic push_word(input func_t func, input logic [FRAME_W-1:0] frame,
                             input bit drain_first);
        stim_word_t w;
        w.func        = func;
        w.frame       = frame;
        w.drain_first = drain_first;
        stim_q.push_back(w);
    endtask

    // Idle percentage of either side for the current third of the run.
    function automatic int idle_pct(input bit rcv_side);
        int third;
        third = (total_words > 0) ? words_taken * 3 / total_words : 0;
        if (third == 0)
            return rcv_side ? 58 : 21;
        else if (third == 1)
            return rcv_side ? 21 : 58;
        return 0;
    endfunction

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || word_taken))
        begin
            word_taken = 1'b0;
            if (stim_q.size() == 0 || $urandom_range(99) < idle_pct(1'b0)
                || (stim_q[0].drain_first && victim_exp_q.size() != 0))
            begin
                s_tvalid <= 1'b0;
            end
            else
            begin
                next_word = stim_q.pop_front();
                if (next_word.drain_first)
                    drain_pauses++;
                s_tvalid <= 1'b1;
                s_tuser  <= next_word.func;
                s_tdata  <= TDATA_W'(next_word.frame);
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= idle_pct(1'b1));
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                word_taken = 1'b1;
                words_taken++;
                apply_word(func_t'(s_tuser), s_tdata[FRAME_W-1:0]);
            end
            if (m_tvalid && m_tready)
            begin
                if (victim_exp_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result word, victim %0d found %0b",
                             $realtime, m_tdata[FRAME_W-1:0], m_tuser);
                end
                else
                begin
                    got_word = victim_exp_q.pop_front();
                    if (m_tdata[FRAME_W-1:0] !== got_word.victim)
                    begin
                        err_count++;
                        $display("%0t: victim mismatch, expected %0d, actual %0d",
                                 $realtime, got_word.victim, m_tdata[FRAME_W-1:0]);
                    end
                    if (m_tuser !== got_word.found)
                    begin
                        err_count++;
                        $display("%0t: found mismatch, expected %0b, actual %0b",
                                 $realtime, got_word.found, m_tuser);
                    end
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("** lru_replacement_list: FAILED **");
        $finish;
    end

    initial
    begin
        int         order[FRAMES];
        int         j;
        int         tmp;
        int         evict_pct;
        bit         hot;
        logic [5:0] f;

        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = FUNC_ACCESS;
        m_tready = 1'b0;

        // Directed: empty evict, extreme frames, hit at the front, hit at the
        // tail and in the middle, drain past empty.
        push_word(FUNC_EVICT,  6'd0,  1'b0);
        push_word(FUNC_ACCESS, 6'd0,  1'b0);
        push_word(FUNC_ACCESS, 6'd63, 1'b0);
        push_word(FUNC_ACCESS, 6'd63, 1'b0);
        push_word(FUNC_ACCESS, 6'd0,  1'b0);
        push_word(FUNC_ACCESS, 6'd21, 1'b0);
        push_word(FUNC_ACCESS, 6'd42, 1'b0);
        push_word(FUNC_ACCESS, 6'd63, 1'b0);
        push_word(FUNC_ACCESS, 6'd21, 1'b0);
        for (int i = 0; i < 5; i++)
            push_word(FUNC_EVICT, 6'(i * 13), 1'b0);
        push_word(FUNC_ACCESS, 6'd42, 1'b1);
        push_word(FUNC_EVICT,  6'd63, 1'b0);
        push_word(FUNC_EVICT,  6'd0,  1'b0);

        // Fill the list with every frame in random order, touch it while
        // full, then drain it past empty.
        for (int i = 0; i < FRAMES; i++)
            order[i] = i;
        for (int i = FRAMES - 1; i > 0; i--)
        begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < FRAMES; i++)
            push_word(FUNC_ACCESS, 6'(order[i]), 1'b0);
        for (int i = 0; i < 40; i++)
            push_word(($urandom_range(9) == 0) ? FUNC_EVICT : FUNC_ACCESS,
                      6'($urandom_range(63)), 1'b0);
        push_word(FUNC_EVICT, 6'($urandom_range(63)), 1'b1);
        for (int i = 0; i < FRAMES + 6; i++)
            push_word(FUNC_EVICT, 6'($urandom_range(63)), 1'b0);

        // Bursts with varying evict rates; a hot set of frames makes hits common.
        while (stim_q.size() < 715)
        begin
            case ($urandom_range(3))
                0: evict_pct = 5;
                1: evict_pct = 25;
                2: evict_pct = 50;
                default: evict_pct = 80;
            endcase
            hot = $urandom_range(1);
            for (int i = 0; i < 40; i++)
            begin
                f = hot ? 6'($urandom_range(7) * 9) : 6'($urandom_range(63));
                push_word(($urandom_range(99) < evict_pct) ? FUNC_EVICT : FUNC_ACCESS,
                          f, $urandom_range(59) == 0);
            end
        end
        total_words = stim_q.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (words_taken < total_words)
            @(negedge clk);
        while (victim_exp_q.size() != 0)
            @(negedge clk);
        repeat (FRAMES + 8) @(negedge clk);

        if (victim_exp_q.size() != 0)
        begin
            err_count++;
            $display("%0t: %0d expected results never arrived", $realtime,
                     victim_exp_q.size());
        end
        $display("Ran %0d words: %0d accesses and %0d evicts, %0d of them on an empty list.",
                 total_words, access_count, evict_count, empty_evict_count);
        $display("The list grew to %0d of %0d frames; the sender drained the block %0d times.",
                 max_depth, FRAMES, drain_pauses);
        if (err_count == 0)
            $display("** lru_replacement_list: PASSED **");
        else
            $display("** lru_replacement_list: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// File: lru_replacement_list.f
src/lru_pkg.sv
src/lru_ram.sv
src/lru_replacement_list.sv
test/tb_lru_replacement_list.sv
